// File: rtl/core/deq_pkg.sv
// Shared types and constants for the double-ended queue.
// Used by deq_cell and double_ended_queue; depends on nothing else.
package deq_pkg;

    localparam int DEPTH_DEF = 32;
    localparam int DATA_W    = 32;
    localparam int OCC_W     = 6;

    // Command codes carried on the mode field
    typedef enum logic [2:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_BACK   = 3'd3,
        MODE_LIST       = 3'd4
    } t_mode;

    // Status codes reported for push and pop
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Operation applied by every cell in the same cycle
    typedef enum logic [2:0] {
        CELL_HOLD       = 3'd0,
        CELL_SHIFT_IN   = 3'd1,
        CELL_APPEND     = 3'd2,
        CELL_SHIFT_OUT  = 3'd3,
        CELL_ROTATE     = 3'd4
    } t_cell_op;

    typedef struct packed {
        t_cell_op                   op;
        logic signed [DATA_W-1:0]   value;
    } t_cell_cmd;

endpackage

// File: rtl/core/deq_cell.sv
// One storage cell of the deque chain; position IDX counts from the front.
// Depends on deq_pkg for the command struct and data width.
module deq_cell #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF,
    parameter int IDX   = 0
) (
    input  logic                                i_clk,
    input  deq_pkg::t_cell_cmd                  i_cmd,
    input  logic [$clog2(DEPTH+1)-1:0]          i_count,
    input  logic signed [deq_pkg::DATA_W-1:0]   i_left,
    input  logic signed [deq_pkg::DATA_W-1:0]   i_right,
    input  logic signed [deq_pkg::DATA_W-1:0]   i_head,
    output logic signed [deq_pkg::DATA_W-1:0]   o_data
);
    import deq_pkg::*;

    localparam int CW = $clog2(DEPTH+1);

    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;
    logic                     w_is_tail;
    logic                     w_is_last;

    // Position checks against the current fill
    assign w_is_tail = (i_count == CW'(IDX));
    assign w_is_last = (i_count == CW'(IDX + 1));

    // Select the next value from the neighbors or the command
    always_comb begin
        n_data = r_data;
        case (i_cmd.op)
            CELL_HOLD:      n_data = r_data;
            CELL_SHIFT_IN:  n_data = i_left;
            CELL_APPEND:    n_data = w_is_tail ? i_cmd.value : r_data;
            CELL_SHIFT_OUT: n_data = i_right;
            CELL_ROTATE:    n_data = w_is_last ? i_head : i_right;
            default:        n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// File: rtl/core/double_ended_queue.sv
// Double-ended queue top level: a chain of DEPTH cells, front at cell 0.
// Each result is registered and appears on the strobe in the cycle after it is accepted.
// Push and pop do not raise busy; a new transaction may follow in the next cycle.
// A listing gives one element per cycle from the front cell while the chain rotates;
// busy stays high after it is accepted until the rest are taken from the front (the rotation pass).
// Reset clears count, the listing counter and output strobe; cell contents stay undefined until written.
module double_ended_queue #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [2:0]                          i_mode,
    input  logic signed [deq_pkg::DATA_W-1:0]   i_value,
    output logic                                o_valid,
    output logic                                o_kind,
    output logic [1:0]                          o_status,
    output logic signed [deq_pkg::DATA_W-1:0]   o_element,
    output logic                                o_no_element,
    output logic [deq_pkg::OCC_W-1:0]           o_occupancy,
    output logic                                o_last
);
    import deq_pkg::*;

    localparam int CW = $clog2(DEPTH+1);

    logic [CW-1:0]            r_count;
    logic [CW-1:0]            n_count;
    logic [CW-1:0]            r_remaining;
    logic [CW-1:0]            n_remaining;
    logic                     r_valid;
    logic                     n_valid;
    logic                     r_kind;
    logic                     n_kind;
    t_status                  r_status;
    t_status                  n_status;
    logic signed [DATA_W-1:0] r_element;
    logic signed [DATA_W-1:0] n_element;
    logic                     r_no_element;
    logic                     n_no_element;
    logic [CW-1:0]            r_occ;
    logic [CW-1:0]            n_occ;
    logic                     r_last;
    logic                     n_last;

    t_cell_cmd                w_cmd;
    logic                     w_accept;
    logic                     w_full;
    logic                     w_empty;
    logic signed [DATA_W-1:0] w_data [DEPTH];

    assign busy     = (r_remaining != '0);
    assign w_accept = start && !busy;
    assign w_full   = (r_count == CW'(DEPTH));
    assign w_empty  = (r_count == '0);

    // Decode the transaction into a chain command and the next result
    always_comb begin
        w_cmd.op     = CELL_HOLD;
        w_cmd.value  = i_value;
        n_count      = r_count;
        n_remaining  = r_remaining;
        n_valid      = 1'b0;
        n_kind       = 1'b0;
        n_status     = ST_OK;
        n_element    = '0;
        n_no_element = 1'b0;
        n_occ        = r_count;
        n_last       = 1'b1;
        if (w_accept) begin
            case (i_mode)
                MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                    n_valid = 1'b1;
                    if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        w_cmd.op = (i_mode == MODE_PUSH_FRONT) ? CELL_SHIFT_IN : CELL_APPEND;
                        n_count  = r_count + 1'b1;
                        n_occ    = r_count + 1'b1;
                    end
                end
                MODE_POP_FRONT, MODE_POP_BACK: begin
                    n_valid = 1'b1;
                    if (w_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        w_cmd.op = (i_mode == MODE_POP_FRONT) ? CELL_SHIFT_OUT : CELL_HOLD;
                        n_count  = r_count - 1'b1;
                        n_occ    = r_count - 1'b1;
                    end
                end
                MODE_LIST: begin
                    n_valid = 1'b1;
                    n_kind  = 1'b1;
                    if (w_empty) begin
                        n_no_element = 1'b1;
                    end else begin
                        // Emit the front now, rotate for the rest
                        w_cmd.op    = CELL_ROTATE;
                        n_element   = w_data[0];
                        n_remaining = r_count - 1'b1;
                        n_last      = (r_count == CW'(1));
                    end
                end
                default: begin
                    n_valid = 1'b0;
                end
            endcase
        end else if (busy) begin
            // Advance the listing by one element
            w_cmd.op    = CELL_ROTATE;
            n_valid     = 1'b1;
            n_kind      = 1'b1;
            n_element   = w_data[0];
            n_remaining = r_remaining - 1'b1;
            n_last      = (r_remaining == CW'(1));
        end
    end

    // Chain of cells, front at index 0
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [DATA_W-1:0] w_left;
        logic signed [DATA_W-1:0] w_right;
        if (g == 0) begin : g_front
            assign w_left = i_value;
        end else begin : g_mid_l
            assign w_left = w_data[g-1];
        end
        if (g == DEPTH-1) begin : g_back
            assign w_right = w_data[g];
        end else begin : g_mid_r
            assign w_right = w_data[g+1];
        end
        deq_cell #(
            .DEPTH (DEPTH),
            .IDX   (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_count (r_count),
            .i_left  (w_left),
            .i_right (w_right),
            .i_head  (w_data[0]),
            .o_data  (w_data[g])
        );
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_remaining <= '0;
            r_valid     <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_remaining <= n_remaining;
            r_valid     <= n_valid;
        end
    end

    // Result payload registers
    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_status     <= n_status;
        r_element    <= n_element;
        r_no_element <= n_no_element;
        r_occ        <= n_occ;
        r_last       <= n_last;
    end

    assign o_valid      = r_valid;
    assign o_kind       = r_kind;
    assign o_status     = r_status;
    assign o_element    = r_element;
    assign o_no_element = r_no_element;
    assign o_occupancy  = OCC_W'(r_occ);
    assign o_last       = r_last;

    // A listing in progress produces an element every cycle
    a_busy_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> (o_valid && o_kind && !o_no_element))
        else $error("listing step produced no element");

    // Fill never exceeds capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("count beyond capacity");

    // The final result of a transaction frees the command port
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> !busy)
        else $error("busy after final result");

    // Count is frozen while a listing walks the chain
    a_list_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> (r_count == $past(r_count)))
        else $error("count moved during listing");

    // An accepted push into a non-full queue grows the fill by one
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_full && (i_mode == MODE_PUSH_FRONT || i_mode == MODE_PUSH_BACK))
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("push did not grow count");

endmodule
